FILE: hw/rtl/indirect_matrix_row_col_delete_assert.svh
// Assertion macros shared by the table controller and datapath.
// No dependencies; included by files that carry concurrent checks.
`ifndef INDIRECT_MATRIX_ROW_COL_DELETE_ASSERT_SVH
`define INDIRECT_MATRIX_ROW_COL_DELETE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IMRCD_ASSERT_NOW(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IMRCD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/imrcd_pkg.sv
// Shared types, constants and helpers for the indirect matrix table.
// No dependencies; imported by imrcd_ctrl, imrcd_dp and the top level.
`default_nettype none

package imrcd_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int LW     = 7;   // live size / config register width
  localparam int DW     = 32;  // cell width
  localparam int FW     = 3;   // func width
  localparam int PW     = 6;   // logical position width
  localparam int CFG_IW = 1;   // config index width

  localparam logic [LW-1:0] CNT_RESET = 7'd64;

  localparam logic [CFG_IW-1:0] REG_COL_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_ROW_COUNT = 1'b1;

  typedef enum logic [FW-1:0] {
    FN_READ      = 3'd0,
    FN_WRITE     = 3'd1,
    FN_DEL_ROW   = 3'd2,
    FN_DEL_COL   = 3'd3,
    FN_INIT      = 3'd4,
    FN_INIT_ZERO = 3'd5
  } func_t;

  typedef struct packed {
    logic latch_in;
    logic set_bad;
    logic map_rd;
    logic cell_wr;
    logic cell_rd;
    logic rd_capture;
    logic idx_load;
    logic shift_rd;
    logic shift_wr;
    logic dec_live;
    logic load_live;
    logic sweep_clr;
    logic sweep_step;
    logic ident_wr;
    logic zero_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  bad_access;
    logic  bad_row;
    logic  bad_col;
    logic  shift_more;
    logic  ident_last;
    logic  cell_last;
  } dp_stat_t;

  // zero maps to one, anything above the table limit maps to the limit
  function automatic logic [LW-1:0] limit_size(input logic [LW-1:0] v, input int max_v);
    logic [LW-1:0] r;
    if (v == '0) begin
      r = LW'(1);
    end else if (int'(v) > max_v) begin
      r = LW'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/imrcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imrcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/imrcd_ctrl.sv
// Controller state machine for the indirect matrix table.
// Depends on imrcd_pkg and indirect_matrix_row_col_delete_assert.svh.
`default_nettype none
`include "indirect_matrix_row_col_delete_assert.svh"

module imrcd_ctrl
  import imrcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [3:0] {
    ST_RST_IDENT,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_RDWAIT,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_IDENT,
    ST_ZERO,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_RST_IDENT: begin
        cmd.ident_wr = 1'b1;
        if (stat.ident_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.func)
          FN_READ, FN_WRITE: begin
            if (stat.bad_access) begin
              cmd.set_bad = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              cmd.map_rd = 1'b1;
              state_nxt  = ST_LOOKUP;
            end
          end
          FN_DEL_ROW, FN_DEL_COL: begin
            if ((stat.func == FN_DEL_ROW) ? stat.bad_row : stat.bad_col) begin
              cmd.set_bad = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              cmd.idx_load = 1'b1;
              state_nxt    = ST_SHIFT_CHK;
            end
          end
          FN_INIT, FN_INIT_ZERO: begin
            cmd.load_live = 1'b1;
            cmd.sweep_clr = 1'b1;
            state_nxt     = ST_IDENT;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_LOOKUP: begin
        if (stat.func == FN_WRITE) begin
          cmd.cell_wr = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.cell_rd = 1'b1;
          state_nxt   = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_SHIFT_CHK: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = ST_SHIFT_WR;
        end else begin
          cmd.dec_live = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = ST_SHIFT_CHK;
      end
      ST_IDENT: begin
        cmd.ident_wr = 1'b1;
        if (stat.ident_last) begin
          if (stat.func == FN_INIT_ZERO) begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = ST_ZERO;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_ZERO: begin
        cmd.zero_wr = 1'b1;
        if (stat.cell_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RST_IDENT;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // one item in flight
  `IMRCD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready_r, !in_ready_r, "second transfer accepted while busy")
  // a result only appears out of the done state
  `IMRCD_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE), "result raised outside done")

endmodule

`default_nettype wire

FILE: hw/rtl/imrcd_dp.sv
// Datapath: item latch, live sizes, index map RAMs, cell RAM and result register.
// Depends on imrcd_pkg, imrcd_ram and indirect_matrix_row_col_delete_assert.svh.
`default_nettype none
`include "indirect_matrix_row_col_delete_assert.svh"

module imrcd_dp
  import imrcd_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [FW-1:0]      in_func,
  input  wire logic [PW-1:0]      in_col,
  input  wire logic [PW-1:0]      in_row,
  input  wire logic signed [DW-1:0] in_value,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [LW-1:0]      cfg_wdata,
  output logic signed [DW-1:0]    out_read_value,
  output logic                    out_bad_index,
  output logic [LW-1:0]           out_cols_live,
  output logic [LW-1:0]           out_rows_live
);

  localparam int CAW   = $clog2(MAX_COLS);
  localparam int RAW   = $clog2(MAX_ROWS);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int CLW   = $clog2(CELLS);
  localparam int MAXM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;

  func_t          func_r;
  logic [PW-1:0]  col_r, row_r;
  logic [DW-1:0]  value_r;
  logic [DW-1:0]  rd_r;
  logic           bad_r;
  logic [LW-1:0]  live_cols_r, live_cols_nxt;
  logic [LW-1:0]  live_rows_r, live_rows_nxt;
  logic [LW-1:0]  col_count_r, row_count_r;
  logic [LW-1:0]  idx_r, idx_nxt;
  logic [CLW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]  out_rd_r;
  logic           out_bad_r;
  logic [LW-1:0]  out_cols_r, out_rows_r;

  logic           is_row;
  logic [LW-1:0]  idx_inc;

  logic           cmap_we, cmap_re;
  logic [CAW-1:0] cmap_waddr, cmap_raddr, cmap_wdata, cmap_rdata;
  logic           rmap_we, rmap_re;
  logic [RAW-1:0] rmap_waddr, rmap_raddr, rmap_wdata, rmap_rdata;
  logic           cell_we;
  logic [CLW-1:0] cell_addr, cell_waddr;
  logic [DW-1:0]  cell_wdata, cell_rdata;

  assign is_row  = (func_r == FN_DEL_ROW);
  assign idx_inc = idx_r + LW'(1);

  // status
  always_comb begin
    stat.func       = func_r;
    stat.bad_col    = (LW'(col_r) >= live_cols_r);
    stat.bad_row    = (LW'(row_r) >= live_rows_r);
    stat.bad_access = stat.bad_col || stat.bad_row;
    stat.shift_more = ({1'b0, idx_r} + (LW+1)'(1)) <
                      {1'b0, (is_row ? live_rows_r : live_cols_r)};
    stat.ident_last = (cnt_r == CLW'(MAXM - 1));
    stat.cell_last  = (cnt_r == CLW'(CELLS - 1));
  end

  // index maps
  assign cmap_re    = cmd.map_rd || (cmd.shift_rd && !is_row);
  assign cmap_raddr = cmd.shift_rd ? CAW'(idx_inc) : CAW'(col_r);
  assign cmap_we    = (cmd.shift_wr && !is_row) ||
                      (cmd.ident_wr && (cnt_r < CLW'(MAX_COLS)));
  assign cmap_waddr = cmd.ident_wr ? CAW'(cnt_r) : CAW'(idx_r);
  assign cmap_wdata = cmd.ident_wr ? CAW'(cnt_r) : cmap_rdata;

  assign rmap_re    = cmd.map_rd || (cmd.shift_rd && is_row);
  assign rmap_raddr = cmd.shift_rd ? RAW'(idx_inc) : RAW'(row_r);
  assign rmap_we    = (cmd.shift_wr && is_row) ||
                      (cmd.ident_wr && (cnt_r < CLW'(MAX_ROWS)));
  assign rmap_waddr = cmd.ident_wr ? RAW'(cnt_r) : RAW'(idx_r);
  assign rmap_wdata = cmd.ident_wr ? RAW'(cnt_r) : rmap_rdata;

  imrcd_ram #(.WIDTH(CAW), .DEPTH(MAX_COLS)) u_col_map (
    .clk   (clk),
    .we    (cmap_we),
    .waddr (cmap_waddr),
    .wdata (cmap_wdata),
    .re    (cmap_re),
    .raddr (cmap_raddr),
    .rdata (cmap_rdata)
  );

  imrcd_ram #(.WIDTH(RAW), .DEPTH(MAX_ROWS)) u_row_map (
    .clk   (clk),
    .we    (rmap_we),
    .waddr (rmap_waddr),
    .wdata (rmap_wdata),
    .re    (rmap_re),
    .raddr (rmap_raddr),
    .rdata (rmap_rdata)
  );

  // cell store: physical row * MAX_COLS + physical column
  assign cell_addr  = CLW'(rmap_rdata) * CLW'(MAX_COLS) + CLW'(cmap_rdata);
  assign cell_we    = cmd.cell_wr || cmd.zero_wr;
  assign cell_waddr = cmd.zero_wr ? cnt_r : cell_addr;
  assign cell_wdata = cmd.zero_wr ? '0 : value_r;

  imrcd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cmd.cell_rd),
    .raddr (cell_addr),
    .rdata (cell_rdata)
  );

  // control state
  always_comb begin
    live_cols_nxt = live_cols_r;
    live_rows_nxt = live_rows_r;
    if (cmd.load_live) begin
      live_cols_nxt = limit_size(col_count_r, MAX_COLS);
      live_rows_nxt = limit_size(row_count_r, MAX_ROWS);
    end else if (cmd.dec_live) begin
      if (is_row) begin
        live_rows_nxt = live_rows_r - LW'(1);
      end else begin
        live_cols_nxt = live_cols_r - LW'(1);
      end
    end

    idx_nxt = idx_r;
    if (cmd.idx_load) begin
      idx_nxt = is_row ? LW'(row_r) : LW'(col_r);
    end else if (cmd.shift_wr) begin
      idx_nxt = idx_inc;
    end

    cnt_nxt = cnt_r;
    if (cmd.sweep_clr) begin
      cnt_nxt = '0;
    end else if (cmd.sweep_step) begin
      cnt_nxt = cnt_r + CLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_cols_r <= limit_size(CNT_RESET, MAX_COLS);
      live_rows_r <= limit_size(CNT_RESET, MAX_ROWS);
      col_count_r <= CNT_RESET;
      row_count_r <= CNT_RESET;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      live_cols_r <= live_cols_nxt;
      live_rows_r <= live_rows_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we && (cfg_index == REG_COL_COUNT)) begin
        col_count_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_ROW_COUNT)) begin
        row_count_r <= cfg_wdata;
      end
    end
  end

  // item latch and result register
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r  <= func_t'(in_func);
      col_r   <= in_col;
      row_r   <= in_row;
      value_r <= in_value;
      rd_r    <= '0;
      bad_r   <= 1'b0;
    end else begin
      if (cmd.rd_capture) begin
        rd_r <= cell_rdata;
      end
      if (cmd.set_bad) begin
        bad_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_rd_r   <= rd_r;
      out_bad_r  <= bad_r;
      out_cols_r <= live_cols_r;
      out_rows_r <= live_rows_r;
    end
  end

  assign out_read_value = out_rd_r;
  assign out_bad_index  = out_bad_r;
  assign out_cols_live  = out_cols_r;
  assign out_rows_live  = out_rows_r;

  // write commands only write cells at in-range positions, never during a zero sweep
  `IMRCD_ASSERT_NOW(a_cell_wr_in_range, clk, rst_n, cmd.cell_wr, !stat.bad_access && !cmd.zero_wr, "cell write for out-of-range position")
  // shifting never reaches past the live region
  `IMRCD_ASSERT_NOW(a_shift_in_live, clk, rst_n, cmd.shift_wr, idx_r < (is_row ? live_rows_r : live_cols_r), "map shift outside live region")

endmodule

`default_nettype wire

FILE: hw/rtl/indirect_matrix_row_col_delete.sv
// Top level of the indirect matrix table: controller plus datapath.
// Depends on imrcd_pkg, imrcd_ctrl, imrcd_dp and imrcd_ram.
//
// Usage: one command per in_ transfer (read, write, remove row, remove column,
// init, init with zero); every command answers with exactly one out_ transfer
// carrying the read value, the bad-index flag and both live sizes.
// cfg_we writes col_count (index 0) or row_count (index 1); they are used by
// the next init. One command is in work at a time; a finished result sits in
// the output register, so a new command is taken even while the receiver
// stalls, but it only finishes after that result is transferred. Steps: read
// looks up the maps, reads the cell and captures it; write looks up the maps
// and writes the cell; an out-of-range position or unused code goes straight
// to the result; remove moves the map entries after the position down (live
// size - position - 1 entries), then lowers the live size; init sets the maps
// to identity, init with zero then clears every cell; the RAM sweeps write one
// entry a cycle. in_ready rises with out_valid. After reset the maps are set
// to identity over max(MAX_COLS, MAX_ROWS) entries with in_ready low; live
// sizes come up at 64 (limited). Cells are undefined until written or zeroed.
`default_nettype none

module indirect_matrix_row_col_delete
  import imrcd_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FW-1:0]        in_func,
  input  wire logic [PW-1:0]        in_col,
  input  wire logic [PW-1:0]        in_row,
  input  wire logic signed [DW-1:0] in_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DW-1:0]      out_read_value,
  output logic                      out_bad_index,
  output logic [LW-1:0]             out_cols_live,
  output logic [LW-1:0]             out_rows_live,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [LW-1:0]        cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  imrcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  imrcd_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_read_value (out_read_value),
    .out_bad_index  (out_bad_index),
    .out_cols_live  (out_cols_live),
    .out_rows_live  (out_rows_live)
  );

endmodule

`default_nettype wire

FILE: tb/sv/indirect_matrix_row_col_delete_test.sv
// Self-checking bench for indirect_matrix_row_col_delete: a directed command table,
// then randomized phases over many table sizes, with random idles and a long stall.
// Depends on imrcd_pkg and the block's RTL; results are predicted by a local model.
`default_nettype none

module indirect_matrix_row_col_delete_test;
  import imrcd_pkg::*;

  localparam int NCOLS = DEF_MAX_COLS;
  localparam int NROWS = DEF_MAX_ROWS;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 112;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 300;

  // spare opcodes, no effect on the table
  localparam logic [FW-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FW-1:0] FN_SPARE7 = 3'd7;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_FULL = 1;
  localparam int IDLE_LIGHT = 2;

  typedef struct packed {
    logic [FW-1:0]        func;
    logic [PW-1:0]        col;
    logic [PW-1:0]        row;
    logic signed [DW-1:0] value;
  } table_cmd_t;

  typedef struct packed {
    logic signed [DW-1:0] read_value;
    logic                 bad_index;
    logic [LW-1:0]        cols_live;
    logic [LW-1:0]        rows_live;
  } table_resp_t;

  typedef struct packed {
    table_cmd_t  cmd;
    logic        fixed;
    table_resp_t resp;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FW-1:0]        in_func = FN_READ;
  logic [PW-1:0]        in_col = '0;
  logic [PW-1:0]        in_row = '0;
  logic signed [DW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_read_value;
  logic                 out_bad_index;
  logic [LW-1:0]        out_cols_live;
  logic [LW-1:0]        out_rows_live;
  logic                 cfg_we = 1'b0;
  logic [CFG_IW-1:0]    cfg_index = REG_COL_COUNT;
  logic [LW-1:0]        cfg_wdata = '0;

  indirect_matrix_row_col_delete uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_col(in_col),
    .in_row(in_row),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_value(out_read_value),
    .out_bad_index(out_bad_index),
    .out_cols_live(out_cols_live),
    .out_rows_live(out_rows_live),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // table model state
  logic signed [DW-1:0] p_cells [NCELLS];
  bit                   p_cell_known [NCELLS];
  logic [PW-1:0]        p_col_map [NCOLS];
  logic [PW-1:0]        p_row_map [NROWS];
  logic [LW-1:0]        p_live_cols = CNT_RESET;
  logic [LW-1:0]        p_live_rows = CNT_RESET;
  logic [LW-1:0]        p_col_count = CNT_RESET;
  logic [LW-1:0]        p_row_count = CNT_RESET;

  table_resp_t   pending_resp [$];
  directed_row_t dir_rows [$];

  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int bad_seen = 0;
  int ready_hold = 0;
  int in_idle = IDLE_FULL;
  int out_idle = IDLE_FULL;
  int cycle_count = 0;

  function automatic int draw_gap(input int mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [LW-1:0] fit_size(input logic [LW-1:0] req, input int top);
    if (req == '0) return LW'(1);
    if (int'(req) > top) return LW'(top);
    return req;
  endfunction

  function automatic void maps_identity();
    for (int i = 0; i < NCOLS; i++) p_col_map[i] = PW'(i);
    for (int i = 0; i < NROWS; i++) p_row_map[i] = PW'(i);
  endfunction

  function automatic int cell_addr(input logic [PW-1:0] col, input logic [PW-1:0] row);
    return int'(p_row_map[row]) * NCOLS + int'(p_col_map[col]);
  endfunction

  function automatic table_resp_t table_apply(input table_cmd_t c);
    table_resp_t r;
    int addr;
    r = '0;
    case (c.func)
      FN_READ, FN_WRITE: begin
        if (c.col >= p_live_cols || c.row >= p_live_rows) begin
          r.bad_index = 1'b1;
        end else begin
          addr = cell_addr(c.col, c.row);
          if (c.func == FN_READ) begin
            r.read_value = p_cells[addr];
          end else begin
            p_cells[addr] = c.value;
            p_cell_known[addr] = 1'b1;
          end
        end
      end
      FN_DEL_ROW: begin
        if (c.row >= p_live_rows) begin
          r.bad_index = 1'b1;
        end else begin
          for (int i = int'(c.row); i + 1 < int'(p_live_rows); i++) p_row_map[i] = p_row_map[i + 1];
          p_live_rows = p_live_rows - 1'b1;
        end
      end
      FN_DEL_COL: begin
        if (c.col >= p_live_cols) begin
          r.bad_index = 1'b1;
        end else begin
          for (int i = int'(c.col); i + 1 < int'(p_live_cols); i++) p_col_map[i] = p_col_map[i + 1];
          p_live_cols = p_live_cols - 1'b1;
        end
      end
      FN_INIT, FN_INIT_ZERO: begin
        p_live_cols = fit_size(p_col_count, NCOLS);
        p_live_rows = fit_size(p_row_count, NROWS);
        maps_identity();
        if (c.func == FN_INIT_ZERO) begin
          for (int i = 0; i < NCELLS; i++) begin
            p_cells[i] = '0;
            p_cell_known[i] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.cols_live = p_live_cols;
    r.rows_live = p_live_rows;
    return r;
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.value = $urandom;
    if (pick < 34) c.func = FN_READ;
    else if (pick < 68) c.func = FN_WRITE;
    else if (pick < 77) c.func = FN_DEL_ROW;
    else if (pick < 86) c.func = FN_DEL_COL;
    else if (pick < 92) c.func = FN_INIT;
    else if (pick < 93) c.func = FN_INIT_ZERO;
    else if (pick < 96) c.func = FN_SPARE6;
    else c.func = FN_SPARE7;
    if ($urandom_range(0, 9) < 8 && p_live_cols != '0)
      c.col = PW'($urandom_range(0, int'(p_live_cols) - 1));
    else
      c.col = PW'($urandom);
    if ($urandom_range(0, 9) < 8 && p_live_rows != '0)
      c.row = PW'($urandom_range(0, int'(p_live_rows) - 1));
    else
      c.row = PW'($urandom);
    // never read a cell that holds no defined value yet
    if (c.func == FN_READ && c.col < p_live_cols && c.row < p_live_rows) begin
      if (!p_cell_known[cell_addr(c.col, c.row)]) c.func = FN_WRITE;
    end
    return c;
  endfunction

  task automatic dir_cmd(input logic [FW-1:0] f, input int c, input int r,
                         input logic [DW-1:0] v);
    directed_row_t d;
    d = '0;
    d.cmd = '{f, PW'(c), PW'(r), v};
    dir_rows.push_back(d);
  endtask

  task automatic dir_chk(input logic [FW-1:0] f, input int c, input int r,
                         input logic [DW-1:0] v, input logic [DW-1:0] rv,
                         input logic bad, input int cl, input int rl);
    directed_row_t d;
    d.cmd = '{f, PW'(c), PW'(r), v};
    d.fixed = 1'b1;
    d.resp = '{rv, bad, LW'(cl), LW'(rl)};
    dir_rows.push_back(d);
  endtask

  task automatic issue(input table_cmd_t c);
    int gap;
    gap = draw_gap(in_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= c.func;
    in_col <= c.col;
    in_row <= c.row;
    in_value <= c.value;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [LW-1:0] cc, input logic [LW-1:0] rc);
    cfg_we <= 1'b1;
    cfg_index <= REG_COL_COUNT;
    cfg_wdata <= cc;
    @(posedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_wdata <= rc;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_col_count = cc;
    p_row_count = rc;
  endtask

  task automatic check_field(input string name, input logic [DW-1:0] want,
                             input logic [DW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_resp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : result_side
    int stall;
    table_resp_t want;
    forever begin
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        repeat (ready_hold) @(posedge clk);
        ready_hold = 0;
      end else begin
        stall = draw_gap(out_idle);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (out_bad_index === 1'b1) bad_seen++;
      if (pending_resp.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected transfer, expected none, actual %0h/%0b/%0d/%0d", $time,
                 out_read_value, out_bad_index, out_cols_live, out_rows_live);
      end else begin
        want = pending_resp.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("bad_index", DW'(want.bad_index), DW'(out_bad_index));
        check_field("cols_live", DW'(want.cols_live), DW'(out_cols_live));
        check_field("rows_live", DW'(want.rows_live), DW'(out_rows_live));
      end
    end
  end

  initial begin : stimulus
    int cfg_at;
    int dir_count;
    logic [LW-1:0] cc;
    logic [LW-1:0] rc;
    table_cmd_t c;
    table_resp_t r;

    maps_identity();

    // reset sizes, extremes of values and positions, spare opcodes
    dir_chk(FN_WRITE, 0, 0, 32'h8000_0000, 32'h0, 1'b0, 64, 64);
    dir_chk(FN_READ, 0, 0, 32'h0, 32'h8000_0000, 1'b0, 64, 64);
    dir_chk(FN_WRITE, 63, 63, 32'h7fff_ffff, 32'h0, 1'b0, 64, 64);
    dir_chk(FN_READ, 63, 63, 32'h0, 32'h7fff_ffff, 1'b0, 64, 64);
    dir_chk(FN_SPARE6, 5, 5, 32'hffff_ffff, 32'h0, 1'b0, 64, 64);
    dir_chk(FN_SPARE7, 63, 0, 32'h1, 32'h0, 1'b0, 64, 64);
    dir_chk(FN_INIT_ZERO, 0, 0, 32'h0, 32'h0, 1'b0, 64, 64);
    dir_chk(FN_READ, 63, 63, 32'h0, 32'h0, 1'b0, 64, 64);
    dir_cmd(FN_WRITE, 63, 63, 32'h1234_5678);
    // removes, and accesses past the live edge
    dir_chk(FN_DEL_ROW, 0, 63, 32'h0, 32'h0, 1'b0, 64, 63);
    dir_chk(FN_READ, 0, 63, 32'h0, 32'h0, 1'b1, 64, 63);
    dir_chk(FN_DEL_COL, 0, 0, 32'h0, 32'h0, 1'b0, 63, 63);
    dir_chk(FN_WRITE, 63, 0, 32'hffff_ffff, 32'h0, 1'b1, 63, 63);
    dir_chk(FN_DEL_COL, 63, 0, 32'h0, 32'h0, 1'b1, 63, 63);
    dir_cmd(FN_DEL_ROW, 0, 10, 32'h0);
    dir_cmd(FN_WRITE, 20, 20, 32'h0bad_cafe);
    dir_cmd(FN_READ, 20, 20, 32'h0);
    dir_cmd(FN_READ, 62, 61, 32'h0);
    // init without zero keeps the cells
    dir_chk(FN_INIT, 0, 0, 32'h0, 32'h0, 1'b0, 64, 64);
    dir_cmd(FN_READ, 63, 63, 32'h0);
    cfg_at = dir_rows.size();
    // col_count 0 taken as 1, then empty axes
    dir_chk(FN_INIT, 0, 0, 32'h0, 32'h0, 1'b0, 1, 2);
    dir_cmd(FN_READ, 0, 1, 32'h0);
    dir_chk(FN_DEL_COL, 0, 0, 32'h0, 32'h0, 1'b0, 0, 2);
    dir_chk(FN_DEL_COL, 0, 0, 32'h0, 32'h0, 1'b1, 0, 2);
    dir_chk(FN_READ, 0, 0, 32'h0, 32'h0, 1'b1, 0, 2);
    dir_chk(FN_DEL_ROW, 0, 1, 32'h0, 32'h0, 1'b0, 0, 1);
    dir_chk(FN_DEL_ROW, 0, 1, 32'h0, 32'h0, 1'b1, 0, 1);
    dir_count = dir_rows.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_count; i++) begin
      if (i == cfg_at) begin
        drain();
        write_sizes(LW'(0), LW'(2));
      end
      issue(dir_rows[i].cmd);
      r = table_apply(dir_rows[i].cmd);
      pending_resp.push_back(dir_rows[i].fixed ? dir_rows[i].resp : r);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0: begin cc = LW'(64); rc = LW'(64); end
        1: begin cc = LW'(1); rc = LW'(1); end
        2: begin cc = LW'(0); rc = LW'(127); end
        3: begin cc = LW'(127); rc = LW'(0); end
        4: begin cc = LW'(2); rc = LW'(3); end
        default: begin
          cc = LW'($urandom_range(1, 64));
          rc = LW'($urandom_range(1, 64));
        end
      endcase
      write_sizes(cc, rc);
      in_idle = p % 3;
      out_idle = (p + 1) % 3;
      c = '0;
      c.func = (p % 2 == 0) ? FN_INIT_ZERO : FN_INIT;
      issue(c);
      pending_resp.push_back(table_apply(c));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 30) ready_hold = LONG_HOLD;
        c = random_cmd();
        issue(c);
        pending_resp.push_back(table_apply(c));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d commands (%0d directed), %0d results checked, %0d out-of-range flags",
             items_sent, dir_count, results_seen, bad_seen);
    $display("%0d random size phases incl. clamped and empty axes, %0d-cycle output stall",
             RAND_PHASES, LONG_HOLD);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
